### sv/lfs_pkg.sv
package lfs_pkg;

  // Default configuration values and parameter defaults
  localparam logic [7:0] THRESHOLD_RST  = 8'd150;
  localparam logic [7:0] INNER_DUTY_RST = 8'd100;
  localparam logic [7:0] OUTER_DUTY_RST = 8'd200;

  localparam int RING_DEPTH_DEF    = 8;
  localparam int AVERAGE_COUNT_DEF = 4;
  localparam int PWM_PERIOD_DEF    = 255;
  localparam int SCAN_TICKS_DEF    = 2;
  localparam int CONTROL_TICKS_DEF = 10;

  // Configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_INNER_DUTY = 2'd1;
  localparam logic [1:0] CFG_OUTER_DUTY = 2'd2;

  // Event kinds
  localparam logic EVENT_TICK = 1'b0;
  localparam logic EVENT_CONV = 1'b1;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] left_sample;
    logic [7:0] right_sample;
  } lfs_in_t;

  typedef struct packed {
    logic       right_motor_on;
    logic       left_motor_on;
    logic       scan_request;
    logic [7:0] left_level;
    logic [7:0] right_level;
  } lfs_out_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic [7:0] inner_duty;
    logic [7:0] outer_duty;
  } lfs_cfg_t;

endpackage

### sv/lfs_ring.sv
module lfs_ring import lfs_pkg::*; #(
  parameter int RING_DEPTH    = RING_DEPTH_DEF,
  parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF,
  parameter int SUM_W         = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             store,
  input  logic [7:0]       left_sample,
  input  logic [7:0]       right_sample,
  output logic [SUM_W-1:0] left_sum,
  output logic [SUM_W-1:0] right_sum
);

  // Newest sample sits at tap 0, so the averaging window uses fixed taps
  logic [7:0]       left_ring_r  [RING_DEPTH];
  logic [7:0]       right_ring_r [RING_DEPTH];
  logic [7:0]       left_ring_nxt  [RING_DEPTH];
  logic [7:0]       right_ring_nxt [RING_DEPTH];
  logic [SUM_W-1:0] left_sum_r, right_sum_r;
  logic [SUM_W-1:0] left_sum_nxt, right_sum_nxt;

  always_comb begin
    left_ring_nxt[0]  = left_sample;
    right_ring_nxt[0] = right_sample;
    for (int i = 1; i < RING_DEPTH; i++) begin
      left_ring_nxt[i]  = left_ring_r[i-1];
      right_ring_nxt[i] = right_ring_r[i-1];
    end
  end

  // Window wraps round the ring when it is longer than the ring
  always_comb begin
    left_sum_nxt  = '0;
    right_sum_nxt = '0;
    for (int k = 0; k < AVERAGE_COUNT; k++) begin
      left_sum_nxt  = left_sum_nxt  + SUM_W'(left_ring_nxt[k % RING_DEPTH]);
      right_sum_nxt = right_sum_nxt + SUM_W'(right_ring_nxt[k % RING_DEPTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        left_ring_r[i]  <= '0;
        right_ring_r[i] <= '0;
      end
      left_sum_r  <= '0;
      right_sum_r <= '0;
    end else if (store) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        left_ring_r[i]  <= left_ring_nxt[i];
        right_ring_r[i] <= right_ring_nxt[i];
      end
      left_sum_r  <= left_sum_nxt;
      right_sum_r <= right_sum_nxt;
    end
  end

  assign left_sum  = left_sum_r;
  assign right_sum = right_sum_r;

endmodule

### sv/lfs_ctrl.sv
module lfs_ctrl import lfs_pkg::*; #(
  parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF,
  parameter int PWM_PERIOD    = PWM_PERIOD_DEF,
  parameter int SCAN_TICKS    = SCAN_TICKS_DEF,
  parameter int CONTROL_TICKS = CONTROL_TICKS_DEF,
  parameter int SUM_W         = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             tick,
  input  lfs_cfg_t         cfg,
  input  logic [SUM_W-1:0] left_sum,
  input  logic [SUM_W-1:0] right_sum,
  output lfs_out_t         result
);

  localparam int AVG_SHIFT = SUM_W + $clog2(AVERAGE_COUNT) + 1;
  localparam int RECIP_W   = AVG_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AvgRecip =
    RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVERAGE_COUNT) - 64'd1) / 64'(AVERAGE_COUNT));
  localparam int SCAN_W = $clog2(SCAN_TICKS + 1);
  localparam int CTRL_W = $clog2(CONTROL_TICKS + 1);

  logic [7:0]        phase_r, phase_nxt;
  logic [8:0]        phase_inc;
  logic [SCAN_W-1:0] scan_cnt_r, scan_cnt_nxt, scan_inc;
  logic [CTRL_W-1:0] ctrl_cnt_r, ctrl_cnt_nxt, ctrl_inc;
  logic [7:0]        left_avg_r, right_avg_r, left_avg_nxt, right_avg_nxt;
  logic              right_en_r, left_en_r, right_en_nxt, left_en_nxt;
  logic              scan_hit, ctrl_hit, right_off, left_off;
  logic [7:0]        right_duty, left_duty;
  logic [PROD_W-1:0] left_prod, right_prod;

  // Divide the window sum by the sample count via reciprocal multiply
  assign left_prod  = PROD_W'(left_sum)  * PROD_W'(AvgRecip);
  assign right_prod = PROD_W'(right_sum) * PROD_W'(AvgRecip);

  assign phase_inc = {1'b0, phase_r} + 9'd1;
  assign phase_nxt = (phase_inc >= 9'(PWM_PERIOD)) ? 8'd0 : phase_inc[7:0];

  assign right_off = right_avg_r > cfg.threshold;
  assign left_off  = left_avg_r  > cfg.threshold;

  always_comb begin
    priority if (right_off && left_off) begin
      right_duty = 8'(PWM_PERIOD);
      left_duty  = 8'd0;
    end else if (right_off) begin
      left_duty  = cfg.inner_duty;
      right_duty = cfg.outer_duty;
    end else if (left_off) begin
      left_duty  = cfg.outer_duty;
      right_duty = cfg.inner_duty;
    end else begin
      right_duty = 8'(PWM_PERIOD);
      left_duty  = 8'(PWM_PERIOD);
    end
  end

  assign scan_inc     = scan_cnt_r + SCAN_W'(1);
  assign scan_hit     = scan_inc >= SCAN_W'(SCAN_TICKS);
  assign scan_cnt_nxt = scan_hit ? '0 : scan_inc;

  assign ctrl_inc     = ctrl_cnt_r + CTRL_W'(1);
  assign ctrl_hit     = ctrl_inc >= CTRL_W'(CONTROL_TICKS);
  assign ctrl_cnt_nxt = ctrl_hit ? '0 : ctrl_inc;

  // Conversions leave the enables, dividers and levels untouched
  always_comb begin
    right_en_nxt  = right_en_r;
    left_en_nxt   = left_en_r;
    left_avg_nxt  = left_avg_r;
    right_avg_nxt = right_avg_r;
    if (tick) begin
      right_en_nxt = phase_nxt < right_duty;
      left_en_nxt  = phase_nxt < left_duty;
      if (ctrl_hit) begin
        left_avg_nxt  = left_prod[AVG_SHIFT +: 8];
        right_avg_nxt = right_prod[AVG_SHIFT +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      scan_cnt_r  <= '0;
      ctrl_cnt_r  <= '0;
      left_avg_r  <= '0;
      right_avg_r <= '0;
      right_en_r  <= 1'b0;
      left_en_r   <= 1'b0;
    end else if (step) begin
      right_en_r  <= right_en_nxt;
      left_en_r   <= left_en_nxt;
      left_avg_r  <= left_avg_nxt;
      right_avg_r <= right_avg_nxt;
      if (tick) begin
        phase_r    <= phase_nxt;
        scan_cnt_r <= scan_cnt_nxt;
        ctrl_cnt_r <= ctrl_cnt_nxt;
      end
    end
  end

  always_comb begin
    result.right_motor_on = right_en_nxt;
    result.left_motor_on  = left_en_nxt;
    result.scan_request   = tick && scan_hit;
    result.left_level     = left_avg_nxt;
    result.right_level    = right_avg_nxt;
  end

endmodule

### sv/line_follower_pwm_steering.sv
// Line follower steering: PWM motor enables from averaged sensor levels.
// A transaction waits in the input register and its result in the output register.
// Throughput: one transaction per cycle unless the output stalls; the window sum is
// registered on each conversion so that a tick needs only one reciprocal multiply.
// Reset (synchronous, active low) clears the sample ring, counters, levels and
// enables, and loads the configuration registers with their defaults.
module line_follower_pwm_steering import lfs_pkg::*; #(
  parameter int RING_DEPTH    = RING_DEPTH_DEF,
  parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF,
  parameter int PWM_PERIOD    = PWM_PERIOD_DEF,
  parameter int SCAN_TICKS    = SCAN_TICKS_DEF,
  parameter int CONTROL_TICKS = CONTROL_TICKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  lfs_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output lfs_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int SUM_W = $clog2(AVERAGE_COUNT * 255 + 1);

  logic             in_valid_r;
  lfs_in_t          in_data_r;
  logic             out_valid_r;
  lfs_out_t         out_data_r;
  lfs_cfg_t         cfg_r;
  logic             advance;
  logic             is_tick;
  logic [SUM_W-1:0] left_sum, right_sum;
  lfs_out_t         result;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign is_tick  = in_data_r.event_kind == EVENT_TICK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold  <= THRESHOLD_RST;
      cfg_r.inner_duty <= INNER_DUTY_RST;
      cfg_r.outer_duty <= OUTER_DUTY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_THRESHOLD:  cfg_r.threshold  <= cfg_wdata;
        CFG_INNER_DUTY: cfg_r.inner_duty <= cfg_wdata;
        CFG_OUTER_DUTY: cfg_r.outer_duty <= cfg_wdata;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // Input register: load whenever the held transaction moves on or none is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  lfs_ring #(
    .RING_DEPTH    (RING_DEPTH),
    .AVERAGE_COUNT (AVERAGE_COUNT),
    .SUM_W         (SUM_W)
  ) u_ring (
    .clk          (clk),
    .rst_n        (rst_n),
    .store        (advance && !is_tick),
    .left_sample  (in_data_r.left_sample),
    .right_sample (in_data_r.right_sample),
    .left_sum     (left_sum),
    .right_sum    (right_sum)
  );

  lfs_ctrl #(
    .AVERAGE_COUNT (AVERAGE_COUNT),
    .PWM_PERIOD    (PWM_PERIOD),
    .SCAN_TICKS    (SCAN_TICKS),
    .CONTROL_TICKS (CONTROL_TICKS),
    .SUM_W         (SUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .tick      (is_tick),
    .cfg       (cfg_r),
    .left_sum  (left_sum),
    .right_sum (right_sum),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
